// ----- sv/acmf_pkg.sv -----
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// acmf_pkg
// Shared sizes, register indexes and controller/datapath interface types for
// the ADC cluster mean filter.
// -----------------------------------------------------------------------------
package acmf_pkg;

   localparam int WINDOW      = 10;
   localparam int SAMPLE_BITS = 12;

   localparam int CLOSE_BITS  = 12;
   localparam int MINGRP_BITS = 4;
   localparam int GROUP_BITS  = 4;
   localparam int CSR_IDX_BITS  = 2;
   localparam int CSR_DATA_BITS = 12;

   // Counts from 0 to WINDOW inclusive.
   localparam int CNT_BITS = $clog2(WINDOW + 1);
   // Holds WINDOW * max_sample plus the rounding term.
   localparam int SUM_BITS = SAMPLE_BITS + $clog2(WINDOW);
   localparam int STEP_MAX  = (SUM_BITS > WINDOW) ? SUM_BITS : WINDOW;
   localparam int STEP_BITS = $clog2(STEP_MAX + 1);

   localparam logic [CSR_IDX_BITS-1:0] CSR_CLOSE_LIMIT = CSR_IDX_BITS'(0);
   localparam logic [CSR_IDX_BITS-1:0] CSR_MIN_GROUP   = CSR_IDX_BITS'(1);

   localparam logic [CLOSE_BITS-1:0]  CLOSE_LIMIT_RESET = CLOSE_BITS'(10);
   localparam logic [MINGRP_BITS-1:0] MIN_GROUP_RESET   = MINGRP_BITS'(8);

   typedef struct packed {
      logic insert;
      logic scan_init;
      logic scan_step;
      logic div_load;
      logic div_step;
      logic load_reject;
      logic load_result;
   } acmf_cmd_type;

   typedef struct packed {
      logic fill_last;
      logic below_min;
   } acmf_status_type;

endpackage

// ----- sv/acmf_ctrl.sv -----
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// acmf_ctrl
// Sequencer: sample collection, group scan, serial divide and result hand-off.
// -----------------------------------------------------------------------------
module acmf_ctrl (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   input  acmf_pkg::acmf_status_type status,
   output acmf_pkg::acmf_cmd_type    cmd
);
   import acmf_pkg::*;

   typedef enum logic [2:0] {
      ST_COLLECT,
      ST_SCAN,
      ST_CHECK,
      ST_DIVIDE,
      ST_FINISH
   } state_type;

   state_type             state_ff, state_in;
   logic [STEP_BITS-1:0]  step_ff, step_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  accept;

   // The last beat of a window waits until the previous result is taken,
   // so the output register is free when the new result lands.
   assign req_ready = (state_ff == ST_COLLECT) && (!status.fill_last || !rsp_valid_ff);
   assign accept    = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      cmd      = '0;
      case (state_ff)
         ST_COLLECT: begin
            cmd.insert = accept;
            if (accept && status.fill_last) begin
               state_in = ST_SCAN;
               step_in  = '0;
            end
         end
         ST_SCAN: begin
            cmd.scan_init = (step_ff == '0);
            cmd.scan_step = (step_ff != '0);
            step_in       = step_ff + STEP_BITS'(1);
            if (step_ff == STEP_BITS'(WINDOW - 1)) begin
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (status.below_min) begin
               cmd.load_reject = 1'b1;
               state_in        = ST_COLLECT;
            end else begin
               cmd.div_load = 1'b1;
               step_in      = '0;
               state_in     = ST_DIVIDE;
            end
         end
         ST_DIVIDE: begin
            cmd.div_step = 1'b1;
            step_in      = step_ff + STEP_BITS'(1);
            if (step_ff == STEP_BITS'(SUM_BITS - 1)) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            cmd.load_result = 1'b1;
            state_in        = ST_COLLECT;
         end
         default: begin
            state_in = ST_COLLECT;
         end
      endcase
   end

   assign rsp_valid_in = (rsp_valid_ff && !rsp_ready) || cmd.load_reject || cmd.load_result;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_COLLECT;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// ----- sv/acmf_datapath.sv -----
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// acmf_datapath
// Sorted sample line, group scan, restoring divider, registers and result.
// -----------------------------------------------------------------------------
module acmf_datapath (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic [acmf_pkg::SAMPLE_BITS-1:0]     req_sample,
   input  logic                                 csr_we,
   input  logic [acmf_pkg::CSR_IDX_BITS-1:0]    csr_index,
   input  logic [acmf_pkg::CSR_DATA_BITS-1:0]   csr_wdata,
   input  acmf_pkg::acmf_cmd_type               cmd,
   output acmf_pkg::acmf_status_type            status,
   output logic                                 rsp_rejected,
   output logic [acmf_pkg::SAMPLE_BITS-1:0]     rsp_filtered_value,
   output logic [acmf_pkg::GROUP_BITS-1:0]      rsp_cluster_size
);
   import acmf_pkg::*;

   localparam int CMP_BITS = (CNT_BITS > MINGRP_BITS) ? CNT_BITS : MINGRP_BITS;

   logic [CLOSE_BITS-1:0]  close_limit_ff;
   logic [MINGRP_BITS-1:0] min_group_ff;
   logic [CNT_BITS-1:0]    fill_ff, fill_in;

   logic [SAMPLE_BITS-1:0] sorted_ff [WINDOW];
   logic [SAMPLE_BITS-1:0] sorted_in [WINDOW];
   logic                   le        [WINDOW];

   logic [SAMPLE_BITS-1:0] prev_ff;
   logic [CNT_BITS-1:0]    run_ff, best_ff, run_in, best_in;
   logic [SUM_BITS-1:0]    run_sum_ff, best_sum_ff, run_sum_in, best_sum_in;
   logic [SAMPLE_BITS-1:0] gap;
   logic [SAMPLE_BITS-1:0] cur;

   logic [SUM_BITS-1:0]    quo_ff;
   logic [CNT_BITS-1:0]    rem_ff;
   logic [CNT_BITS:0]      trial;
   logic                   trial_ge;

   logic                   rejected_ff;
   logic [SAMPLE_BITS-1:0] value_ff;
   logic [GROUP_BITS-1:0]  size_ff;

   // Configuration registers; bits above a register's width are dropped.
   always_ff @(posedge clock) begin
      if (reset) begin
         close_limit_ff <= CLOSE_LIMIT_RESET;
         min_group_ff   <= MIN_GROUP_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_CLOSE_LIMIT: close_limit_ff <= csr_wdata[CLOSE_BITS-1:0];
            CSR_MIN_GROUP:   min_group_ff   <= csr_wdata[MINGRP_BITS-1:0];
            default: begin
            end
         endcase
      end
   end

   assign status.fill_last = (fill_ff == CNT_BITS'(WINDOW - 1));
   assign status.below_min = (CMP_BITS'(best_ff) < CMP_BITS'(min_group_ff));

   always_comb begin
      fill_in = fill_ff;
      if (cmd.insert) begin
         fill_in = status.fill_last ? '0 : fill_ff + CNT_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
      end else begin
         fill_ff <= fill_in;
      end
   end

   // Insertion into the sorted line: every entry decides on its own whether
   // it keeps its value, takes the new beat or takes its lower neighbor.
   // Entries at or above the fill count hold stale data and never win.
   always_comb begin
      for (int k = 0; k < WINDOW; k++) begin
         le[k] = (CNT_BITS'(k) < fill_ff) && (sorted_ff[k] <= req_sample);
      end
      for (int k = 0; k < WINDOW; k++) begin
         sorted_in[k] = sorted_ff[k];
         if (cmd.insert) begin
            if (le[k]) begin
               sorted_in[k] = sorted_ff[k];
            end else if (k == 0) begin
               sorted_in[k] = req_sample;
            end else if (le[k-1]) begin
               sorted_in[k] = req_sample;
            end else begin
               sorted_in[k] = sorted_ff[k-1];
            end
         end else if (cmd.scan_init || cmd.scan_step) begin
            // The scan reads the head and shifts the line down by one.
            if (k < WINDOW - 1) begin
               sorted_in[k] = sorted_ff[k+1];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < WINDOW; k++) begin
         sorted_ff[k] <= sorted_in[k];
      end
   end

   // Group scan over the sorted line, lowest values first. A strictly larger
   // run replaces the best, so the lowest group wins a tie.
   assign cur = sorted_ff[0];
   assign gap = cur - prev_ff;

   always_comb begin
      run_in      = run_ff;
      run_sum_in  = run_sum_ff;
      best_in     = best_ff;
      best_sum_in = best_sum_ff;
      if (cmd.scan_init) begin
         run_in      = CNT_BITS'(1);
         run_sum_in  = SUM_BITS'(cur);
         best_in     = CNT_BITS'(1);
         best_sum_in = SUM_BITS'(cur);
      end else if (cmd.scan_step) begin
         if (gap <= close_limit_ff) begin
            run_in     = run_ff + CNT_BITS'(1);
            run_sum_in = run_sum_ff + SUM_BITS'(cur);
         end else begin
            run_in     = CNT_BITS'(1);
            run_sum_in = SUM_BITS'(cur);
         end
         if (run_in > best_ff) begin
            best_in     = run_in;
            best_sum_in = run_sum_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.scan_init || cmd.scan_step) begin
         prev_ff <= cur;
      end
      run_ff      <= run_in;
      run_sum_ff  <= run_sum_in;
      best_ff     <= best_in;
      best_sum_ff <= best_sum_in;
   end

   // Restoring divider, one quotient bit per cycle. The numerator carries
   // the rounding term so the quotient comes out rounded up.
   assign trial    = {rem_ff, quo_ff[SUM_BITS-1]};
   assign trial_ge = (trial >= (CNT_BITS + 1)'(best_ff));

   always_ff @(posedge clock) begin
      if (cmd.div_load) begin
         quo_ff <= best_sum_ff + SUM_BITS'(best_ff) - SUM_BITS'(1);
         rem_ff <= '0;
      end else if (cmd.div_step) begin
         quo_ff <= {quo_ff[SUM_BITS-2:0], trial_ge};
         rem_ff <= trial_ge ? CNT_BITS'(trial - (CNT_BITS + 1)'(best_ff))
                            : CNT_BITS'(trial);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_reject) begin
         rejected_ff <= 1'b1;
         value_ff    <= '0;
         size_ff     <= GROUP_BITS'(best_ff);
      end else if (cmd.load_result) begin
         rejected_ff <= 1'b0;
         value_ff    <= quo_ff[SAMPLE_BITS-1:0];
         size_ff     <= GROUP_BITS'(best_ff);
      end
   end

   assign rsp_rejected       = rejected_ff;
   assign rsp_filtered_value = value_ff;
   assign rsp_cluster_size   = size_ff;

endmodule

// ----- sv/adc_cluster_mean_filter_core.sv -----
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// adc_cluster_mean_filter_core
// Largest-cluster mean filter over windows of raw ADC samples.
// -----------------------------------------------------------------------------
// Each sample beat is inserted straight into a sorted line of WINDOW
// entries, so the window is already ordered when it fills. After the last
// beat of a window the block stops taking samples for the group scan, the
// decision and, for an accepted window, a one-bit-per-cycle divider and the
// load of the result; a rejected window skips the divider. The result sits
// in an output register; samples of the next window keep flowing while it
// waits, and only the last beat of that next window waits for the result to
// be taken.
// -----------------------------------------------------------------------------
module adc_cluster_mean_filter_core (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic [acmf_pkg::SAMPLE_BITS-1:0]     req_sample,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic                                 rsp_rejected,
   output logic [acmf_pkg::SAMPLE_BITS-1:0]     rsp_filtered_value,
   output logic [acmf_pkg::GROUP_BITS-1:0]      rsp_cluster_size,
   input  logic                                 csr_we,
   input  logic [acmf_pkg::CSR_IDX_BITS-1:0]    csr_index,
   input  logic [acmf_pkg::CSR_DATA_BITS-1:0]   csr_wdata
);
   import acmf_pkg::*;

   acmf_cmd_type    cmd;
   acmf_status_type status;

   acmf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   acmf_datapath u_datapath (
      .clock              (clock),
      .reset              (reset),
      .req_sample         (req_sample),
      .csr_we             (csr_we),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata),
      .cmd                (cmd),
      .status             (status),
      .rsp_rejected       (rsp_rejected),
      .rsp_filtered_value (rsp_filtered_value),
      .rsp_cluster_size   (rsp_cluster_size)
   );

endmodule

// ----- sv/acmf_checker.sv -----
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// acmf_checker
// Port-level checks on the result channel of the cluster mean filter.
// -----------------------------------------------------------------------------
module acmf_checker (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   input  logic                                 rsp_rejected,
   input  logic [acmf_pkg::SAMPLE_BITS-1:0]     rsp_filtered_value,
   input  logic [acmf_pkg::GROUP_BITS-1:0]      rsp_cluster_size
);
   import acmf_pkg::*;

   // A stalled result beat holds its payload.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_rejected)
         && $stable(rsp_filtered_value) && $stable(rsp_cluster_size))
      else $error("result beat changed while stalled");

   // A rejected window reports a zero value.
   a_reject_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_rejected |-> rsp_filtered_value == '0)
      else $error("rejected window carries a nonzero value");

   // The winning group holds at least one and at most a window of samples.
   a_size_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_cluster_size != '0
         && 32'(rsp_cluster_size) <= 32'(WINDOW))
      else $error("group size out of range");

   // No result can be pending right after reset.
   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

endmodule

bind adc_cluster_mean_filter_core acmf_checker u_acmf_checker (
   .clock              (clock),
   .reset              (reset),
   .rsp_valid          (rsp_valid),
   .rsp_ready          (rsp_ready),
   .rsp_rejected       (rsp_rejected),
   .rsp_filtered_value (rsp_filtered_value),
   .rsp_cluster_size   (rsp_cluster_size)
);

// ----- test/tb_top.sv -----
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the ADC cluster mean filter core.
// -----------------------------------------------------------------------------
// Samples go in as whole windows. The bench keeps its own copy of the window
// and the two filter registers, and works out the expected verdict, mean and
// group size whenever a window fills. Each result beat is compared with the
// oldest outstanding window. The sender works in random bursts and the
// receiver stalls on its own pattern. One test holds the output off long
// enough for the core to stall its input. The registers are reprogrammed
// only while the core is drained, across their extremes and random values.
// -----------------------------------------------------------------------------
module tb_top;
   import acmf_pkg::*;

   typedef logic [SAMPLE_BITS-1:0] sample_type;

   typedef struct packed {
      logic                   rejected;
      logic [SAMPLE_BITS-1:0] value;
      logic [GROUP_BITS-1:0]  size;
   } window_result_type;

   typedef enum int {STYLE_NOISE, STYLE_CLUSTER, STYLE_TIE, STYLE_EXTREME} window_style_type;
   typedef enum int {PACE_OPEN, PACE_COIN, PACE_QUARTER, PACE_MOSTLY} pace_mode_type;

   localparam int SAMPLE_MAX     = (1 << SAMPLE_BITS) - 1;
   localparam int WATCHDOG_LIMIT = 3000;
   localparam int HOLD_CYCLES    = 400;
   localparam int SETTLE_CYCLES  = 40;
   localparam int DRAIN_CYCLES   = 60;

   // Indexes that decode to no register.
   localparam logic [CSR_IDX_BITS-1:0] CSR_SPARE_A = CSR_IDX_BITS'(2);
   localparam logic [CSR_IDX_BITS-1:0] CSR_SPARE_B = CSR_IDX_BITS'(3);

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_valid = 1'b0;
   logic                     req_ready;
   sample_type               req_sample = '0;
   logic                     rsp_valid;
   logic                     rsp_ready = 1'b0;
   logic                     rsp_rejected;
   logic [SAMPLE_BITS-1:0]   rsp_filtered_value;
   logic [GROUP_BITS-1:0]    rsp_cluster_size;
   logic                     csr_we = 1'b0;
   logic [CSR_IDX_BITS-1:0]  csr_index = '0;
   logic [CSR_DATA_BITS-1:0] csr_wdata = '0;

   // Bench copy of the core state.
   logic [CLOSE_BITS-1:0]    gap_limit = CLOSE_LIMIT_RESET;
   logic [MINGRP_BITS-1:0]   need_count = MIN_GROUP_RESET;
   sample_type               window_fill [WINDOW];
   int                       fill_level = 0;
   window_result_type        pending_results [$];

   sample_type               staged [WINDOW];
   int                       burst_left = 0;
   logic                     hold_req = 1'b0;
   int                       mismatches = 0;
   int                       idle_cycles = 0;

   adc_cluster_mean_filter_core i_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_sample         (req_sample),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_rejected       (rsp_rejected),
      .rsp_filtered_value (rsp_filtered_value),
      .rsp_cluster_size   (rsp_cluster_size),
      .csr_we             (csr_we),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   // Sorts the filled window, finds the largest run of close neighbours and
   // forms the verdict with the current register values.
   function automatic window_result_type cluster_mean_of();
      sample_type        v [WINDOW];
      sample_type        t;
      int                run, run_start, best, best_start, sum, mean;
      window_result_type r;
      for (int i = 0; i < WINDOW; i++) v[i] = window_fill[i];
      for (int i = 0; i < WINDOW - 1; i++) begin
         for (int j = 0; j < WINDOW - 1 - i; j++) begin
            if (v[j] > v[j + 1]) begin
               t = v[j];
               v[j] = v[j + 1];
               v[j + 1] = t;
            end
         end
      end
      best = 1;
      best_start = 0;
      run = 1;
      run_start = 0;
      for (int i = 1; i < WINDOW; i++) begin
         if (int'(v[i]) - int'(v[i - 1]) <= int'(gap_limit)) begin
            run++;
         end else begin
            run = 1;
            run_start = i;
         end
         // Strictly greater, so the lowest-valued group keeps a tie.
         if (run > best) begin
            best = run;
            best_start = run_start;
         end
      end
      r.size = GROUP_BITS'(best);
      if (best < int'(need_count)) begin
         r.rejected = 1'b1;
         r.value = '0;
      end else begin
         sum = 0;
         for (int i = best_start; i < best_start + best; i++) sum += v[i];
         mean = (sum + best - 1) / best;
         r.rejected = 1'b0;
         r.value = SAMPLE_BITS'(mean);
      end
      return r;
   endfunction

   function automatic void note_mismatch(input string field, input int want, input int got);
      mismatches++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
   endfunction

   // Sends one sample beat, with the sender's burst and gap pattern.
   task automatic send_sample(input sample_type s);
      int gap, pick;
      if (burst_left == 0) begin
         pick = $urandom_range(0, 9);
         if (pick < 4) gap = 0;
         else if (pick < 8) gap = $urandom_range(1, 3);
         else gap = $urandom_range(4, 20);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 40);
      end
      burst_left--;
      req_valid <= 1'b1;
      req_sample <= s;
      do @(posedge clock); while (!req_ready);
      window_fill[fill_level] = s;
      fill_level++;
      if (fill_level == WINDOW) begin
         pending_results.push_back(cluster_mean_of());
         fill_level = 0;
      end
   endtask

   task automatic send_window();
      for (int i = 0; i < WINDOW; i++) send_sample(staged[i]);
   endtask

   // Lays a chain of neighbours into the staged window. Steps mostly stay
   // within the closeness limit; now and then one breaks the chain.
   task automatic walk_cluster(input int first, input int count, input int base);
      int cur, step;
      cur = base;
      for (int i = 0; i < count; i++) begin
         staged[first + i] = SAMPLE_BITS'(cur);
         if ($urandom_range(0, 9) == 0) step = int'(gap_limit) + 1;
         else step = $urandom_range(0, int'(gap_limit));
         cur += step;
         if (cur > SAMPLE_MAX) cur = SAMPLE_MAX;
      end
   endtask

   task automatic build_window(input window_style_type style);
      int half, j;
      sample_type t;
      for (int i = 0; i < WINDOW; i++) staged[i] = SAMPLE_BITS'($urandom_range(0, SAMPLE_MAX));
      case (style)
         STYLE_CLUSTER: begin
            walk_cluster(0, $urandom_range(1, WINDOW), $urandom_range(0, SAMPLE_MAX));
         end
         STYLE_TIE: begin
            half = $urandom_range(2, WINDOW / 2);
            walk_cluster(0, half, $urandom_range(0, 1800));
            walk_cluster(half, half, $urandom_range(2300, SAMPLE_MAX));
         end
         STYLE_EXTREME: begin
            for (int i = 0; i < WINDOW; i++) begin
               t = ($urandom_range(0, 1) == 1) ? sample_type'(SAMPLE_MAX) : '0;
               staged[i] = t ^ sample_type'($urandom_range(0, 3));
            end
         end
         default: ;
      endcase
      // Arrival order must not matter, so shuffle.
      for (int i = WINDOW - 1; i > 0; i--) begin
         j = $urandom_range(0, i);
         t = staged[i];
         staged[i] = staged[j];
         staged[j] = t;
      end
   endtask

   task automatic run_windows(input int count);
      int pick;
      window_style_type style;
      for (int n = 0; n < count; n++) begin
         pick = $urandom_range(0, 19);
         if (pick < 3) style = STYLE_NOISE;
         else if (pick < 14) style = STYLE_CLUSTER;
         else if (pick < 17) style = STYLE_TIE;
         else style = STYLE_EXTREME;
         build_window(style);
         send_window();
      end
   endtask

   // Drains the core, then writes both registers and one unused index.
   // The upper bits of the group size write are junk and must be dropped.
   task automatic set_filter(input logic [CLOSE_BITS-1:0] gap, input logic [MINGRP_BITS-1:0] need);
      logic [CSR_IDX_BITS-1:0]  idx [3];
      logic [CSR_DATA_BITS-1:0] dat [3];
      logic [CSR_DATA_BITS-MINGRP_BITS-1:0] junk;
      junk = (CSR_DATA_BITS - MINGRP_BITS)'(
         $urandom_range(0, (1 << (CSR_DATA_BITS - MINGRP_BITS)) - 1));
      idx[0] = CSR_CLOSE_LIMIT;
      dat[0] = gap;
      idx[1] = ($urandom_range(0, 1) == 1) ? CSR_SPARE_A : CSR_SPARE_B;
      dat[1] = CSR_DATA_BITS'($urandom_range(0, (1 << CSR_DATA_BITS) - 1));
      idx[2] = CSR_MIN_GROUP;
      dat[2] = {junk, need};
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      for (int i = 0; i < 3; i++) begin
         csr_we <= 1'b1;
         csr_index <= idx[i];
         csr_wdata <= dat[i];
         @(posedge clock);
         case (idx[i])
            CSR_CLOSE_LIMIT: gap_limit = dat[i][CLOSE_BITS-1:0];
            CSR_MIN_GROUP:   need_count = dat[i][MINGRP_BITS-1:0];
            default: ;
         endcase
      end
      csr_we <= 1'b0;
   endtask

   // Reset values first: a tight cluster at the top of the range with
   // outliers at the bottom, then two equal groups where the lower one must
   // win, rejected at first and accepted once the group size is lowered.
   task automatic test_directed_windows();
      staged = '{12'd4095, 12'd0, 12'd4090, 12'd4095, 12'd5,
                 12'd4089, 12'd4094, 12'd4091, 12'd4093, 12'd4092};
      send_window();
      for (int pass = 0; pass < 2; pass++) begin
         staged = '{12'd100, 12'd3000, 12'd101, 12'd3001, 12'd102,
                    12'd3002, 12'd103, 12'd3003, 12'd104, 12'd3004};
         send_window();
         if (pass == 0) set_filter(CLOSE_BITS'(10), MINGRP_BITS'(5));
      end
   endtask

   task automatic test_register_extremes();
      set_filter('0, '0);
      run_windows(3);
      set_filter('1, '1);
      run_windows(3);
      set_filter('0, MINGRP_BITS'(1));
      run_windows(3);
      set_filter(CLOSE_BITS'(1), MINGRP_BITS'(WINDOW));
      run_windows(3);
      set_filter('1, MINGRP_BITS'(WINDOW));
      run_windows(3);
      set_filter(CLOSE_BITS'(10), MINGRP_BITS'(WINDOW + 1));
      run_windows(3);
      set_filter(CLOSE_BITS'(64), MINGRP_BITS'(3));
      run_windows(3);
   endtask

   // The receiver holds off while four windows are offered, so the core
   // fills up and has to stall its input.
   task automatic test_output_stall();
      set_filter(CLOSE_BITS'(40), MINGRP_BITS'(4));
      hold_req = 1'b1;
      run_windows(4);
   endtask

   task automatic test_random_windows();
      logic [CLOSE_BITS-1:0] gap;
      for (int phase = 0; phase < 10; phase++) begin
         case ($urandom_range(0, 4))
            0: gap = '0;
            1: gap = '1;
            2: gap = CLOSE_BITS'($urandom_range(0, 16));
            3: gap = CLOSE_BITS'($urandom_range(0, 200));
            default: gap = CLOSE_BITS'($urandom_range(0, SAMPLE_MAX));
         endcase
         set_filter(gap, MINGRP_BITS'($urandom_range(0, (1 << MINGRP_BITS) - 1)));
         run_windows(8);
      end
   endtask

   // Receiver pacing: modes of random length, plus the long hold on request.
   initial begin : rsp_pacing
      pace_mode_type mode;
      int left;
      mode = PACE_OPEN;
      left = 0;
      forever begin
         @(posedge clock);
         if (hold_req) begin
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES - 1) @(posedge clock);
            hold_req = 1'b0;
         end else begin
            if (left == 0) begin
               mode = pace_mode_type'($urandom_range(0, 3));
               left = $urandom_range(8, 80);
            end
            left--;
            case (mode)
               PACE_OPEN:    rsp_ready <= 1'b1;
               PACE_COIN:    rsp_ready <= ($urandom_range(0, 1) == 1);
               PACE_QUARTER: rsp_ready <= (left % 4 == 0);
               default:      rsp_ready <= ($urandom_range(0, 9) != 0);
            endcase
         end
      end
   end

   always @(posedge clock) begin : result_check
      window_result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_results.size() == 0) begin
            note_mismatch("unexpected result beat, value", -1, int'(rsp_filtered_value));
         end else begin
            want = pending_results.pop_front();
            if (rsp_rejected !== want.rejected)
               note_mismatch("rejected", int'(want.rejected), int'(rsp_rejected));
            if (rsp_filtered_value !== want.value)
               note_mismatch("filtered_value", int'(want.value), int'(rsp_filtered_value));
            if (rsp_cluster_size !== want.size)
               note_mismatch("cluster_size", int'(want.size), int'(rsp_cluster_size));
         end
      end
   end

   always @(posedge clock) begin : watchdog
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) || csr_we) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t: no beat accepted for %0d cycles", $time, WATCHDOG_LIMIT);
         $display("Simulation FAILED");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed_windows();
      test_register_extremes();
      test_output_stall();
      test_random_windows();
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

// ----- files.f -----
sv/acmf_pkg.sv
sv/acmf_ctrl.sv
sv/acmf_datapath.sv
sv/adc_cluster_mean_filter_core.sv
sv/acmf_checker.sv
test/tb_top.sv
